FILE: hdl/wgm_pkg.sv
// Package for the wildcard glob matcher: store sizes, derived widths,
// command and state codes, and the status struct between loader and walker.
// No dependencies.
`default_nettype none

package wgm_pkg;

    localparam int PAT_MAX = 64;
    localparam int SUB_MAX = 256;

    localparam int PAT_AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int SUB_AW = (SUB_MAX > 1) ? $clog2(SUB_MAX) : 1;
    localparam int PAT_LW = $clog2(PAT_MAX + 1);
    localparam int SUB_LW = $clog2(SUB_MAX + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        CMD_PAT_BYTE = 2'd0,
        CMD_SUB_BYTE = 2'd1,
        CMD_PAT_END  = 2'd2,
        CMD_MATCH    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_WALK,
        ST_TAIL,
        ST_FINISH
    } wgm_state_t;

    typedef struct packed {
        logic [PAT_LW-1:0] pat_len;
        logic [SUB_LW-1:0] sub_len;
        logic              any_overflow;
    } wgm_status_t;

endpackage

`default_nettype wire

FILE: hdl/wgm_in_if.sv
// Input channel of the glob matcher: one command item per handshake.
// Uses nothing outside this file.
`default_nettype none

interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/wgm_out_if.sv
// Result channel of the glob matcher: match flag and overflow flag.
// Uses nothing outside this file.
`default_nettype none

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/wildcard_glob_matcher.sv
// Wildcard glob matcher, top level: input and result channels, two byte
// stores, loader and match sequencer.
// Depends on wgm_pkg, wgm_in_if, wgm_out_if, wgm_byte_mem, wgm_loader, wgm_walker.
//
// Usage:
//   in_ch carries items {cmd, data_byte}: pattern byte, subject byte,
//   end of pattern, and end of subject (run match). out_ch returns one
//   item {matched, overflow} per match command.
//   Load items are taken one per cycle. A match item is taken, then input
//   stalls while the sequencer walks the stores: the equality pre-check
//   reads one byte when the lengths differ, up to L = pattern length when
//   they agree and none for an overflow or an empty pattern; then come the
//   walk and tail steps (each step is one read of the pattern and subject
//   RAMs) and a step to post the result. The result appears on out_ch the
//   cycle after it is posted.
//   The result sits in an output register; the next load items are taken
//   while it waits. A following match finishes its walk and then holds
//   until the pending result is taken.
//   Reset clears lengths, flags, walk state and the output valid; the
//   store contents are not cleared, and only data below the lengths is used.
`default_nettype none

module wildcard_glob_matcher (
    input  wire logic clk,
    input  wire logic rst_n,
    wgm_in_if.sink    in_ch,
    wgm_out_if.source out_ch
);

    logic accept;
    logic start;
    logic idle;
    logic clear_subject;

    wgm_pkg::wgm_status_t status;

    logic                       pat_we;
    logic [wgm_pkg::PAT_AW-1:0] pat_waddr;
    logic [wgm_pkg::PAT_AW-1:0] pat_raddr;
    logic [7:0]                 pat_rdata;
    logic                       sub_we;
    logic [wgm_pkg::SUB_AW-1:0] sub_waddr;
    logic [wgm_pkg::SUB_AW-1:0] sub_raddr;
    logic [7:0]                 sub_rdata;
    logic [7:0]                 wdata;

    assign in_ch.ready = idle;
    assign accept      = in_ch.valid && idle;
    assign start       = accept && (in_ch.cmd == wgm_pkg::CMD_MATCH);

    wgm_loader u_loader (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (in_ch.cmd),
        .data_byte     (in_ch.data_byte),
        .clear_subject (clear_subject),
        .status        (status),
        .pat_we        (pat_we),
        .pat_waddr     (pat_waddr),
        .sub_we        (sub_we),
        .sub_waddr     (sub_waddr),
        .wdata         (wdata)
    );

    wgm_byte_mem #(
        .DEPTH (wgm_pkg::PAT_MAX)
    ) u_pat_mem (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    wgm_byte_mem #(
        .DEPTH (wgm_pkg::SUB_MAX)
    ) u_sub_mem (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (wdata),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

    wgm_walker u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .status        (status),
        .pc            (pat_rdata),
        .sc            (sub_rdata),
        .pat_raddr     (pat_raddr),
        .sub_raddr     (sub_raddr),
        .idle          (idle),
        .clear_subject (clear_subject),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_matched   (out_ch.matched),
        .out_overflow  (out_ch.overflow)
    );

endmodule

`default_nettype wire

FILE: hdl/wgm_byte_mem.sv
// Generic byte RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module wgm_byte_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [7:0]                                wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [7:0]                                rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/wgm_loader.sv
// Load side: pattern and subject lengths, truncation and overflow flags,
// write ports of both byte stores. Depends on wgm_pkg.
`default_nettype none

module wgm_loader (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [1:0]                 cmd,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       clear_subject,
    output wgm_pkg::wgm_status_t            status,
    output logic                            pat_we,
    output logic [wgm_pkg::PAT_AW-1:0]      pat_waddr,
    output logic                            sub_we,
    output logic [wgm_pkg::SUB_AW-1:0]      sub_waddr,
    output logic [7:0]                      wdata
);

    logic [wgm_pkg::PAT_LW-1:0] pat_len_reg, pat_len_next;
    logic [wgm_pkg::SUB_LW-1:0] sub_len_reg, sub_len_next;
    logic pat_trunc_reg, pat_trunc_next;
    logic sub_trunc_reg, sub_trunc_next;
    logic pat_ovf_reg, pat_ovf_next;
    logic sub_ovf_reg, sub_ovf_next;
    logic pat_closed_reg, pat_closed_next;

    logic [wgm_pkg::PAT_LW-1:0] pat_len_eff;
    logic pat_trunc_eff;
    logic pat_ovf_eff;

    always_comb
    begin
        pat_len_next    = pat_len_reg;
        sub_len_next    = sub_len_reg;
        pat_trunc_next  = pat_trunc_reg;
        sub_trunc_next  = sub_trunc_reg;
        pat_ovf_next    = pat_ovf_reg;
        sub_ovf_next    = sub_ovf_reg;
        pat_closed_next = pat_closed_reg;
        pat_we          = 1'b0;
        sub_we          = 1'b0;

        // a byte after end of pattern starts a new pattern
        pat_len_eff   = pat_closed_reg ? '0 : pat_len_reg;
        pat_trunc_eff = pat_closed_reg ? 1'b0 : pat_trunc_reg;
        pat_ovf_eff   = pat_closed_reg ? 1'b0 : pat_ovf_reg;

        pat_waddr = pat_len_eff[wgm_pkg::PAT_AW-1:0];
        sub_waddr = sub_len_reg[wgm_pkg::SUB_AW-1:0];
        wdata     = data_byte;

        if (accept)
        begin
            unique case (cmd)
                wgm_pkg::CMD_PAT_BYTE:
                begin
                    pat_closed_next = 1'b0;
                    pat_len_next    = pat_len_eff;
                    pat_trunc_next  = pat_trunc_eff;
                    pat_ovf_next    = pat_ovf_eff;
                    if (!pat_trunc_eff)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            pat_trunc_next = 1'b1;
                        end
                        else if (32'(pat_len_eff) >= wgm_pkg::PAT_MAX)
                        begin
                            pat_ovf_next = 1'b1;
                        end
                        else
                        begin
                            pat_we       = 1'b1;
                            pat_len_next = pat_len_eff + 1'b1;
                        end
                    end
                end
                wgm_pkg::CMD_SUB_BYTE:
                begin
                    if (!sub_trunc_reg)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            sub_trunc_next = 1'b1;
                        end
                        else if (32'(sub_len_reg) >= wgm_pkg::SUB_MAX)
                        begin
                            sub_ovf_next = 1'b1;
                        end
                        else
                        begin
                            sub_we       = 1'b1;
                            sub_len_next = sub_len_reg + 1'b1;
                        end
                    end
                end
                wgm_pkg::CMD_PAT_END:
                begin
                    pat_closed_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (clear_subject)
        begin
            sub_len_next   = '0;
            sub_trunc_next = 1'b0;
            sub_ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg    <= '0;
            sub_len_reg    <= '0;
            pat_trunc_reg  <= 1'b0;
            sub_trunc_reg  <= 1'b0;
            pat_ovf_reg    <= 1'b0;
            sub_ovf_reg    <= 1'b0;
            pat_closed_reg <= 1'b0;
        end
        else
        begin
            pat_len_reg    <= pat_len_next;
            sub_len_reg    <= sub_len_next;
            pat_trunc_reg  <= pat_trunc_next;
            sub_trunc_reg  <= sub_trunc_next;
            pat_ovf_reg    <= pat_ovf_next;
            sub_ovf_reg    <= sub_ovf_next;
            pat_closed_reg <= pat_closed_next;
        end
    end

    assign status.pat_len      = pat_len_reg;
    assign status.sub_len      = sub_len_reg;
    assign status.any_overflow = pat_ovf_reg | sub_ovf_reg;

endmodule

`default_nettype wire

FILE: hdl/wgm_walker.sv
// Match sequencer: equality pre-check, backtracking walk and tail pass over
// the two byte stores, one read of each store per step; holds the result register.
// Depends on wgm_pkg.
`default_nettype none

module wgm_walker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire wgm_pkg::wgm_status_t       status,
    input  wire logic [7:0]                 pc,
    input  wire logic [7:0]                 sc,
    output logic [wgm_pkg::PAT_AW-1:0]      pat_raddr,
    output logic [wgm_pkg::SUB_AW-1:0]      sub_raddr,
    output logic                            idle,
    output logic                            clear_subject,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_matched,
    output logic                            out_overflow
);

    localparam int PLW = wgm_pkg::PAT_LW;
    localparam int SLW = wgm_pkg::SUB_LW;

    wgm_pkg::wgm_state_t state_reg, state_next;

    logic [PLW-1:0] pp_reg, pp_next;
    logic [SLW-1:0] sp_reg, sp_next;
    logic [PLW-1:0] star_pos_reg, star_pos_next;
    logic [SLW-1:0] star_sp_reg, star_sp_next;
    logic [PLW-1:0] ero_pos_reg, ero_pos_next;
    logic [SLW-1:0] ero_sp_reg, ero_sp_next;
    logic [7:0]     ero_byte_reg, ero_byte_next;
    logic star_seen_reg, star_seen_next;
    logic ero_seen_reg, ero_seen_next;
    logic res_match_reg, res_match_next;
    logic res_ovf_reg, res_ovf_next;
    logic out_valid_reg, out_valid_next;
    logic out_match_reg, out_match_next;
    logic out_ovf_reg, out_ovf_next;

    logic done;
    logic to_walk;
    logic to_tail;
    logic unload;
    logic pat_end;
    logic sub_end;
    logic [PLW-1:0] star_resume;

    assign pat_end     = pp_reg >= status.pat_len;
    assign sub_end     = sp_reg >= status.sub_len;
    assign star_resume = star_pos_reg + 1'b1;
    assign unload      = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wgm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = done ? wgm_pkg::ST_FINISH : wgm_pkg::ST_CMP;
                end
            end
            wgm_pkg::ST_CMP:
            begin
                priority if (done)
                    state_next = wgm_pkg::ST_FINISH;
                else if (to_walk)
                    state_next = wgm_pkg::ST_WALK;
            end
            wgm_pkg::ST_WALK:
            begin
                priority if (done)
                    state_next = wgm_pkg::ST_FINISH;
                else if (to_tail)
                    state_next = wgm_pkg::ST_TAIL;
            end
            wgm_pkg::ST_TAIL:
            begin
                if (done)
                    state_next = wgm_pkg::ST_FINISH;
            end
            wgm_pkg::ST_FINISH:
            begin
                if (unload)
                    state_next = wgm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wgm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pp_next        = pp_reg;
        sp_next        = sp_reg;
        star_pos_next  = star_pos_reg;
        star_sp_next   = star_sp_reg;
        ero_pos_next   = ero_pos_reg;
        ero_sp_next    = ero_sp_reg;
        ero_byte_next  = ero_byte_reg;
        star_seen_next = star_seen_reg;
        ero_seen_next  = ero_seen_reg;
        res_match_next = res_match_reg;
        res_ovf_next   = res_ovf_reg;
        out_match_next = out_match_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        clear_subject  = 1'b0;
        done           = 1'b0;
        to_walk        = 1'b0;
        to_tail        = 1'b0;

        unique case (state_reg)
            wgm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pp_next = '0;
                    sp_next = '0;
                    if (status.any_overflow)
                    begin
                        done           = 1'b1;
                        res_match_next = 1'b0;
                        res_ovf_next   = 1'b1;
                    end
                    else if (status.pat_len == '0)
                    begin
                        done           = 1'b1;
                        res_match_next = (status.sub_len == '0);
                        res_ovf_next   = 1'b0;
                    end
                end
            end
            wgm_pkg::ST_CMP:
            begin
                res_ovf_next = 1'b0;
                if (pp_reg == '0 && status.pat_len == PLW'(1) && pc == wgm_pkg::CH_STAR)
                begin
                    done           = 1'b1;
                    res_match_next = 1'b1;
                end
                else if (32'(status.pat_len) != 32'(status.sub_len) || pc != sc)
                begin
                    to_walk = 1'b1;
                end
                else if (pp_reg + 1'b1 == status.pat_len)
                begin
                    done           = 1'b1;
                    res_match_next = 1'b1;
                end
                else
                begin
                    pp_next = pp_reg + 1'b1;
                    sp_next = sp_reg + 1'b1;
                end

                if (to_walk)
                begin
                    pp_next        = '0;
                    sp_next        = '0;
                    star_pos_next  = '0;
                    star_sp_next   = '0;
                    ero_pos_next   = '0;
                    ero_sp_next    = '0;
                    ero_byte_next  = '0;
                    star_seen_next = 1'b0;
                    ero_seen_next  = 1'b0;
                end
            end
            wgm_pkg::ST_WALK:
            begin
                priority if (sub_end)
                begin
                    to_tail = 1'b1;
                end
                else if (pat_end)
                begin
                    if (star_seen_reg)
                    begin
                        pp_next      = star_resume;
                        star_sp_next = star_sp_reg + 1'b1;
                        sp_next      = star_sp_reg + 1'b1;
                    end
                    else
                    begin
                        done           = 1'b1;
                        res_match_next = 1'b0;
                    end
                end
                else if (pc == wgm_pkg::CH_DOT)
                begin
                    pp_next = pp_reg + 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                else if (pc == wgm_pkg::CH_QUEST)
                begin
                    ero_seen_next = 1'b1;
                    ero_pos_next  = pp_reg;
                    ero_sp_next   = sp_reg;
                    ero_byte_next = sc;
                    pp_next       = pp_reg + 1'b1;
                    sp_next       = sp_reg + 1'b1;
                end
                else if (pc == wgm_pkg::CH_STAR)
                begin
                    star_seen_next = 1'b1;
                    star_pos_next  = pp_reg;
                    star_sp_next   = sp_reg;
                    pp_next        = pp_reg + 1'b1;
                end
                else if (pc != sc)
                begin
                    priority if (ero_seen_reg)
                    begin
                        pp_next       = ero_pos_reg + 1'b1;
                        sp_next       = ero_sp_reg;
                        ero_seen_next = 1'b0;
                    end
                    else if (star_seen_reg)
                    begin
                        pp_next      = star_resume;
                        star_sp_next = star_sp_reg + 1'b1;
                        sp_next      = star_sp_reg + 1'b1;
                    end
                    else
                    begin
                        done           = 1'b1;
                        res_match_next = 1'b0;
                    end
                end
                else
                begin
                    if (ero_seen_reg && ero_byte_reg != sc)
                        ero_seen_next = 1'b0;
                    pp_next = pp_reg + 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
            end
            wgm_pkg::ST_TAIL:
            begin
                priority if (pat_end)
                begin
                    done           = 1'b1;
                    res_match_next = 1'b1;
                end
                else if (pc == wgm_pkg::CH_STAR)
                begin
                    pp_next = pp_reg + 1'b1;
                end
                else if (pc == wgm_pkg::CH_QUEST)
                begin
                    if (sub_end && sp_reg != '0)
                        sp_next = sp_reg - 1'b1;
                    pp_next = pp_reg + 1'b1;
                end
                else
                begin
                    done           = 1'b1;
                    res_match_next = 1'b0;
                end
            end
            wgm_pkg::ST_FINISH:
            begin
                if (unload)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = res_match_reg;
                    out_ovf_next   = res_ovf_reg;
                    clear_subject  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // read address follows the next position so data lines up with the state
    assign pat_raddr = pp_next[wgm_pkg::PAT_AW-1:0];
    assign sub_raddr = sp_next[wgm_pkg::SUB_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wgm_pkg::ST_IDLE;
            pp_reg        <= '0;
            sp_reg        <= '0;
            star_pos_reg  <= '0;
            star_sp_reg   <= '0;
            ero_pos_reg   <= '0;
            ero_sp_reg    <= '0;
            ero_byte_reg  <= '0;
            star_seen_reg <= 1'b0;
            ero_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pp_reg        <= pp_next;
            sp_reg        <= sp_next;
            star_pos_reg  <= star_pos_next;
            star_sp_reg   <= star_sp_next;
            ero_pos_reg   <= ero_pos_next;
            ero_sp_reg    <= ero_sp_next;
            ero_byte_reg  <= ero_byte_next;
            star_seen_reg <= star_seen_next;
            ero_seen_reg  <= ero_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_match_reg <= res_match_next;
        res_ovf_reg   <= res_ovf_next;
        out_match_reg <= out_match_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign idle         = (state_reg == wgm_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_matched  = out_match_reg;
    assign out_overflow = out_ovf_reg;

endmodule

`default_nettype wire
